/* design/lps_pkg.sv */
// Package for the LRU page stack: shared widths, defaults, controller states
// and the command word that passes from the controller to the datapath.
// No dependencies.
package lps_pkg;

  localparam int WAYS_DEF       = 4;
  localparam int PAGE_WIDTH_DEF = 8;
  localparam int IN_PAGE_W      = 8;
  localparam int POS_W          = 2;
  localparam int EVICT_W        = 8;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_OUT
  } lps_state_t;

  typedef struct packed {
    logic capture;
  } lps_cmd_t;

endpackage

/* design/lps_ctrl.sv */
// Controller for the LRU page stack: accepts one word, then holds the result
// word until it is taken. Depends on lps_pkg.
module lps_ctrl
  import lps_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output lps_cmd_t cmd
);

  lps_state_t state_r;
  lps_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd.capture = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_OUT: begin
        out_valid = 1'b1;
      end
      default: begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while a result word is pending");
  a_result_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> out_valid)
    else $error("accepted word did not produce a result word");
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before it was taken");
`endif

endmodule

/* design/lps_datapath.sv */
// Datapath for the LRU page stack: recency-ordered slots with valid bits,
// parallel compare, shift and the registered result word. Depends on lps_pkg.
module lps_datapath
  import lps_pkg::*;
#(
  parameter int WAYS       = WAYS_DEF,
  parameter int PAGE_WIDTH = PAGE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lps_cmd_t             cmd,
  input  logic [IN_PAGE_W-1:0] in_page,
  output logic                 res_hit,
  output logic [POS_W-1:0]     res_hit_position,
  output logic                 res_evicted_valid,
  output logic [EVICT_W-1:0]   res_evicted_page
);

  localparam int IDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W = $clog2(WAYS + 1);

  logic [PAGE_WIDTH-1:0] slot_page_r   [WAYS];
  logic [PAGE_WIDTH-1:0] slot_page_nxt [WAYS];
  logic [WAYS-1:0]       slot_valid_r;
  logic [WAYS-1:0]       slot_valid_nxt;

  logic [PAGE_WIDTH-1:0] pg;
  logic [WAYS-1:0]       hit_vec;
  logic [IDX_W-1:0]      match_idx;
  logic [CNT_W-1:0]      fill;
  logic                  found;
  logic                  full;
  logic [31:0]           match_ext;

  logic                  hit_r;
  logic [POS_W-1:0]      pos_r;
  logic                  ev_valid_r;
  logic [EVICT_W-1:0]    ev_page_r;

  assign pg        = PAGE_WIDTH'(in_page);
  assign found     = |hit_vec;
  assign full      = &slot_valid_r;
  assign match_ext = 32'(match_idx);

  always_comb begin
    match_idx = '0;
    fill      = CNT_W'(WAYS);
    for (int i = WAYS - 1; i >= 0; i--) begin
      hit_vec[i] = slot_valid_r[i] && (slot_page_r[i] == pg);
      if (hit_vec[i]) begin
        match_idx = IDX_W'(i);
      end
      if (!slot_valid_r[i]) begin
        fill = CNT_W'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      slot_page_nxt[i]  = slot_page_r[i];
      slot_valid_nxt[i] = slot_valid_r[i];
      if (found) begin
        if (CNT_W'(i + 1) == fill) begin
          slot_page_nxt[i] = pg;
        end else if ((IDX_W'(i) >= match_idx) && (CNT_W'(i + 1) < fill)) begin
          slot_page_nxt[i] = slot_page_r[(i + 1) % WAYS];
        end
      end else if (!full) begin
        if (CNT_W'(i) == fill) begin
          slot_page_nxt[i]  = pg;
          slot_valid_nxt[i] = 1'b1;
        end
      end else begin
        if (i == WAYS - 1) begin
          slot_page_nxt[i] = pg;
        end else begin
          slot_page_nxt[i] = slot_page_r[(i + 1) % WAYS];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
    end else if (cmd.capture) begin
      slot_valid_r <= slot_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WAYS; i++) begin
        slot_page_r[i] <= '0;
      end
    end else if (cmd.capture) begin
      slot_page_r <= slot_page_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hit_r      <= found;
      pos_r      <= found ? match_ext[POS_W-1:0] : '0;
      ev_valid_r <= !found && full;
      ev_page_r  <= (!found && full) ? EVICT_W'(slot_page_r[0]) : '0;
    end
  end

  assign res_hit           = hit_r;
  assign res_hit_position  = pos_r;
  assign res_evicted_valid = ev_valid_r;
  assign res_evicted_page  = ev_page_r;

`ifndef SYNTHESIS
  a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (slot_valid_r & (slot_valid_r + 1'b1)) == '0)
    else $error("valid slots are not packed from the oldest end");
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> !(res_hit && res_evicted_valid))
    else $error("hit and eviction reported for the same word");
  a_evict_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture && !full |=> !res_evicted_valid)
    else $error("eviction reported with a free slot");
  a_full_stays_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |=> full)
    else $error("occupancy dropped on a full stack");
`endif

endmodule

/* design/lru_page_stack_unit.sv */
// Each accepted word is looked up and the stack is updated in the cycle it is
// accepted; the result word appears from the next cycle and is held in the
// output register until taken. The controller takes no new word while a
// result waits, so it accepts the next word only after that result is taken.
// Top level of the LRU page stack. Depends on lps_pkg, lps_ctrl, lps_datapath.
module lru_page_stack_unit
  import lps_pkg::*;
#(
  parameter int WAYS       = WAYS_DEF,
  parameter int PAGE_WIDTH = PAGE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [IN_PAGE_W-1:0] in_page,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_hit,
  output logic [POS_W-1:0]     out_hit_position,
  output logic                 out_evicted_valid,
  output logic [EVICT_W-1:0]   out_evicted_page
);

  lps_cmd_t cmd;

  lps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lps_datapath #(
    .WAYS       (WAYS),
    .PAGE_WIDTH (PAGE_WIDTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_page           (in_page),
    .res_hit           (out_hit),
    .res_hit_position  (out_hit_position),
    .res_evicted_valid (out_evicted_valid),
    .res_evicted_page  (out_evicted_page)
  );

endmodule

/* sim/lps_result_checker.sv */
// Result checker for the LRU page stack: watches both channels, predicts the
// result word of every accepted page access and compares it field by field.
// Depends on lps_pkg for the port widths and the default stack size.
module lps_result_checker
  import lps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [IN_PAGE_W-1:0] in_page,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 out_hit,
  input  logic [POS_W-1:0]     out_hit_position,
  input  logic                 out_evicted_valid,
  input  logic [EVICT_W-1:0]   out_evicted_page,
  output int                   mismatches,
  output int                   outstanding
);

  localparam int WAYS       = WAYS_DEF;
  localparam int PAGE_WIDTH = PAGE_WIDTH_DEF;

  typedef struct packed {
    logic               hit;
    logic [POS_W-1:0]   hit_position;
    logic               evicted_valid;
    logic [EVICT_W-1:0] evicted_page;
  } access_result_t;

  logic [PAGE_WIDTH-1:0] stack_page [WAYS];
  bit                    stack_live [WAYS];
  access_result_t        results_due [$];
  access_result_t        want;

  function automatic access_result_t lru_access(logic [IN_PAGE_W-1:0] raw);
    access_result_t        r;
    logic [PAGE_WIDTH-1:0] pg;
    int                    fill;
    int                    match;
    r     = '0;
    pg    = raw[PAGE_WIDTH-1:0];
    fill  = WAYS;
    match = -1;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (!stack_live[i]) fill = i;
      if (stack_live[i] && stack_page[i] == pg) match = i;
    end
    if (match >= 0) begin
      for (int i = match; i < fill - 1; i++) stack_page[i] = stack_page[i + 1];
      stack_page[fill - 1] = pg;
      r.hit          = 1'b1;
      r.hit_position = POS_W'(match);
    end else if (fill < WAYS) begin
      stack_page[fill] = pg;
      stack_live[fill] = 1'b1;
    end else begin
      r.evicted_valid = 1'b1;
      r.evicted_page  = EVICT_W'(stack_page[0]);
      for (int i = 0; i < WAYS - 1; i++) stack_page[i] = stack_page[i + 1];
      stack_page[WAYS - 1] = pg;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WAYS; i++) begin
        stack_page[i] = '0;
        stack_live[i] = 1'b0;
      end
      results_due.delete();
    end else begin
      if (in_valid && in_ready) results_due.push_back(lru_access(in_page));
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $error("result word arrived with no page access pending");
          mismatches++;
        end else begin
          want = results_due.pop_front();
          if (out_hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, out_hit);
            mismatches++;
          end
          if (out_hit_position !== want.hit_position) begin
            $error("hit_position: expected %0d, got %0d",
                   want.hit_position, out_hit_position);
            mismatches++;
          end
          if (out_evicted_valid !== want.evicted_valid) begin
            $error("evicted_valid: expected %0d, got %0d",
                   want.evicted_valid, out_evicted_valid);
            mismatches++;
          end
          if (out_evicted_page !== want.evicted_page) begin
            $error("evicted_page: expected %0d, got %0d",
                   want.evicted_page, out_evicted_page);
            mismatches++;
          end
        end
      end
    end
    outstanding = results_due.size();
  end

endmodule

/* sim/tb.sv */
// Testbench top for the LRU page stack: drives page accesses under several
// idling patterns, stalls the result side and gives the verdict.
// Depends on lps_pkg, lru_page_stack_unit and lps_result_checker.
module tb;
  import lps_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 240;
  localparam int PHASE_ITEMS    = 146;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [IN_PAGE_W-1:0] in_page   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_hit;
  logic [POS_W-1:0]     out_hit_position;
  logic                 out_evicted_valid;
  logic [EVICT_W-1:0]   out_evicted_page;

  int mismatches;
  int outstanding;
  int src_idle   = 0;
  int sink_stall = 0;
  int holds_asked   = 0;
  int holds_granted = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  logic [IN_PAGE_W-1:0] pool [6];
  int                   pool_n;

  logic [IN_PAGE_W-1:0] directed_pages [20] = '{
    8'd0, 8'd0, 8'd255, 8'd1, 8'd2, 8'd0, 8'd1, 8'd0, 8'd1, 8'd0,
    8'd128, 8'd255, 8'd255, 8'd85, 8'd170, 8'd85, 8'd128, 8'd0, 8'd1, 8'd255
  };
  int src_idle_by_phase   [5] = '{0, 63, 0, 19, 0};
  int sink_stall_by_phase [5] = '{0, 0, 63, 19, 30};

  lru_page_stack_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_page           (in_page),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hit           (out_hit),
    .out_hit_position  (out_hit_position),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page)
  );

  lps_result_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_page           (in_page),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hit           (out_hit),
    .out_hit_position  (out_hit_position),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .mismatches        (mismatches),
    .outstanding       (outstanding)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // The long hold keeps the result side blocked so that the stack backs up.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_granted != holds_asked) begin
      holds_granted <= holds_granted + 1;
      hold_left     <= LONG_HOLD;
      out_ready     <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= sink_stall);
    end
  end

  always @(posedge clk) begin
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_page(logic [IN_PAGE_W-1:0] p);
    while ($urandom_range(0, 99) < src_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_page  <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [IN_PAGE_W-1:0] next_page();
    if ($urandom_range(0, 99) < 80) return pool[$urandom_range(0, pool_n - 1)];
    return IN_PAGE_W'($urandom_range(0, 255));
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_pages[i]) send_page(directed_pages[i]);
    for (int ph = 0; ph < 5; ph++) begin
      src_idle   = src_idle_by_phase[ph];
      sink_stall = sink_stall_by_phase[ph];
      if (ph == 4) holds_asked++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // A small working set gives hits at every depth; a larger one evicts.
        if (n % 40 == 0) begin
          pool_n = $urandom_range(3, 6);
          foreach (pool[k]) pool[k] = IN_PAGE_W'($urandom_range(0, 255));
        end
        send_page(next_page());
      end
    end
    in_valid   <= 1'b0;
    sink_stall = 0;
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
